// ===== rtl/core/wlrs_pkg.sv =====
// Shared types and constants for the wear-leveled ring store.
// No dependencies; imported by every module of the block.
package wlrs_pkg;

    localparam int DATA_W     = 64;   // packet field width
    localparam int NBYTES     = 8;    // bytes carried by the packet field
    localparam int CNT_W      = 3;    // byte counter width
    localparam int BYTES_W    = 4;    // packet_bytes register width
    localparam int SLOTS_W    = 5;    // slot_count register width
    localparam int ADDR_W     = 16;   // address width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = 112;  // result tdata, whole bytes

    localparam logic REQ_SAVE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd2;

    // Commands from the sequencer to the mark scanner.
    typedef struct packed {
        logic start;      // begin a scan at slot 0
        logic clear_all;  // drop every mark
        logic set_en;     // mark the slot at set_idx
    } scan_ctrl_t;

endpackage

// ===== rtl/core/wlrs_cksum.sv =====
// Byte-serial mask and checksum unit: one packet byte per cycle.
// Depends on wlrs_pkg.
module wlrs_cksum
    import wlrs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DATA_W-1:0]   load_data,
    input  logic [BYTES_W-1:0]  bytes,
    output logic                busy,
    output logic [DATA_W-1:0]   value,
    output logic [7:0]          sum
);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] shift_reg;
    logic [DATA_W-1:0] value_reg;
    logic [7:0]        sum_reg;
    logic [7:0]        kept;

    // Drop bytes at or above the packet size.
    assign kept = ({1'b0, cnt_reg} < bytes) ? shift_reg[7:0] : 8'h00;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            shift_reg <= load_data;
            value_reg <= '0;
            sum_reg   <= 8'h00;
        end else if (busy_reg) begin
            shift_reg <= shift_reg >> 8;
            value_reg <= {kept, value_reg[DATA_W-1:8]};
            sum_reg   <= sum_reg + kept;
            cnt_reg   <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NBYTES - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy  = busy_reg;
    assign value = value_reg;
    assign sum   = sum_reg;

endmodule

// ===== rtl/core/wlrs_marks.sv =====
// Slot mark flags and the serial scanner that finds the first empty slot.
// Depends on wlrs_pkg.
module wlrs_marks
    import wlrs_pkg::*;
#(
    parameter int MAX_SLOTS = 16
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  scan_ctrl_t                                          ctrl,
    input  logic [$clog2(MAX_SLOTS + 1)-1:0]                    n_eff,
    input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] set_idx,
    output logic                                                busy,
    output logic [$clog2(MAX_SLOTS + 1)-1:0]                    pos
);

    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [MAX_SLOTS-1:0] valid_reg;
    logic [MAX_SLOTS-1:0] valid_next;
    logic                 busy_reg;
    logic [SW-1:0]        pos_reg;

    // Clear first, then mark, so a full ring restarts with slot 0 set.
    always_comb begin
        valid_next = ctrl.clear_all ? '0 : valid_reg;
        if (ctrl.set_en) begin
            valid_next[set_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
        end else begin
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end else if (busy_reg) begin
                // Stop at the first empty mark or at the end of the ring.
                if (pos_reg == n_eff || !valid_reg[pos_reg[IW-1:0]]) begin
                    busy_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            valid_reg <= valid_next;
        end
    end

    assign busy = busy_reg;
    assign pos  = pos_reg;

endmodule

// ===== rtl/core/wear_leveling_ring_store_top.sv =====
// Top level of the wear-leveled ring store: sequencer, packet memory, config.
// Depends on wlrs_pkg, wlrs_marks and wlrs_cksum.
//
// Usage:
//   s_ channel: one request per transfer. s_tuser = req_type (0 save, 1 read),
//   s_tdata = packet_data. m_ channel: one result per request, m_tuser =
//   status_code, m_tdata carries the remaining result fields.
//   cfg_ channel: register writes (index 0 base, 1 slot count, 2 packet
//   bytes), always ready; write only while no request is in flight.
// Sequence:
//   One request at a time. The mark scanner checks one slot mark per cycle;
//   the checksum unit works through the packet one byte at a time. A save
//   runs the checksum alongside the scan; a read runs the scan, then the
//   memory read, then the checksum; a read with no saved data skips the
//   memory read and the checksum. The next request is taken in the cycle
//   after the result loads.
// Reset: aresetn low clears all slot marks and the control state; packet
//   memory contents stay undefined until written. Config returns to
//   base 0, 4 slots, 2 bytes.
// Stall: a finished result holds in the output register while m_tready is
//   low; the next request is accepted meanwhile and waits for that register
//   before its result is loaded.
module wear_leveling_ring_store_top
    import wlrs_pkg::*;
#(
    parameter int MAX_SLOTS        = 16,
    parameter int MAX_PACKET_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [63:0] packet_data
    input  logic                  s_tuser,   // [0] req_type
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [63:0] read_data, [67:64] slot_index, [83:68] slot_address,
    // [91:84] checksum, [92] ring_cleared, [108:93] end_address, rest zero
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tuser,   // [0] status_code
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW = 8 * MAX_PACKET_BYTES;
    localparam int MW = SW + BYTES_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_RD_MEM, ST_RD_LOAD, ST_RD_SUM, ST_ADDR, ST_DONE
    } state_t;

    // ---------------- configuration registers ----------------
    logic [ADDR_W-1:0]  base_reg;
    logic [SLOTS_W-1:0] slot_count_reg;
    logic [BYTES_W-1:0] packet_bytes_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg         <= '0;
            slot_count_reg   <= SLOTS_W'(4);
            packet_bytes_reg <= BYTES_W'(2);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BASE:  base_reg         <= cfg_data;
                CFG_SLOTS: slot_count_reg   <= cfg_data[SLOTS_W-1:0];
                CFG_BYTES: packet_bytes_reg <= cfg_data[BYTES_W-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // Clamp the slot count and packet size into their usable ranges.
    logic [SW-1:0]      n_eff;
    logic [BYTES_W-1:0] b_eff;

    always_comb begin
        if (slot_count_reg == '0) begin
            n_eff = SW'(1);
        end else if (int'(slot_count_reg) > MAX_SLOTS) begin
            n_eff = SW'(MAX_SLOTS);
        end else begin
            n_eff = SW'(slot_count_reg);
        end
        if (packet_bytes_reg == '0) begin
            b_eff = BYTES_W'(1);
        end else if (int'(packet_bytes_reg) > MAX_PACKET_BYTES) begin
            b_eff = BYTES_W'(MAX_PACKET_BYTES);
        end else begin
            b_eff = packet_bytes_reg;
        end
    end

    // ---------------- sequencer state ----------------
    state_t            state_reg;
    logic              req_reg;
    logic [IW-1:0]     idx_reg;
    logic              cleared_reg;
    logic              status_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [7:0]        sum_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] end_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_rdata_reg;
    logic [IW-1:0]     out_idx_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [7:0]        out_sum_reg;
    logic              out_cleared_reg;
    logic              out_status_reg;
    logic [ADDR_W-1:0] out_end_reg;

    logic s_accept;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // ---------------- mark scanner ----------------
    scan_ctrl_t    scan_ctrl;
    logic [IW-1:0] set_idx;
    logic          scan_busy;
    logic [SW-1:0] scan_pos;
    logic          scan_full;

    assign scan_full = (scan_pos == n_eff);
    // A full ring restarts at slot 0.
    assign set_idx   = scan_full ? '0 : IW'(scan_pos);

    wlrs_marks #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_marks (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .n_eff   (n_eff),
        .set_idx (set_idx),
        .busy    (scan_busy),
        .pos     (scan_pos)
    );

    // ---------------- checksum unit ----------------
    logic              cks_start;
    logic [DATA_W-1:0] cks_load;
    logic              cks_busy;
    logic [DATA_W-1:0] cks_value;
    logic [7:0]        cks_sum;

    wlrs_cksum u_cksum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cks_start),
        .load_data (cks_load),
        .bytes     (b_eff),
        .busy      (cks_busy),
        .value     (cks_value),
        .sum       (cks_sum)
    );

    // ---------------- packet memory ----------------
    logic [PW-1:0] mem [MAX_SLOTS];
    logic [PW-1:0] mem_q;
    logic          mem_we;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[set_idx] <= cks_value[PW-1:0];
        end
        if (state_reg == ST_RD_MEM) begin
            mem_q <= mem[idx_reg];
        end
    end

    // Scan is finished, and for a save the masked packet is ready too.
    logic scan_fin;
    assign scan_fin = (state_reg == ST_SCAN) && !scan_busy
                      && (req_reg == REQ_READ || !cks_busy);

    always_comb begin
        scan_ctrl           = '0;
        cks_start           = 1'b0;
        cks_load            = s_tdata;
        mem_we              = 1'b0;
        if (state_reg == ST_IDLE && s_accept) begin
            scan_ctrl.start = 1'b1;
            cks_start       = (s_tuser == REQ_SAVE);
        end
        if (scan_fin && req_reg == REQ_SAVE) begin
            mem_we              = 1'b1;
            scan_ctrl.set_en    = 1'b1;
            scan_ctrl.clear_all = scan_full;
        end
        if (state_reg == ST_RD_LOAD) begin
            cks_start = 1'b1;
            cks_load  = DATA_W'(mem_q);
        end
    end

    // ---------------- address arithmetic ----------------
    logic [MW-1:0] prod_idx;
    logic [MW-1:0] prod_end;

    assign prod_idx = MW'(idx_reg) * MW'(b_eff);
    assign prod_end = MW'(n_eff) * MW'(b_eff);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // Load a finished result, or drop the one just transferred.
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        req_reg     <= s_tuser;
                        cleared_reg <= 1'b0;
                        status_reg  <= 1'b0;
                        rdata_reg   <= '0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_fin) begin
                        if (req_reg == REQ_SAVE) begin
                            idx_reg     <= set_idx;
                            cleared_reg <= scan_full;
                            sum_reg     <= cks_sum;
                            state_reg   <= ST_ADDR;
                        end else if (scan_pos == '0) begin
                            // nothing saved yet
                            idx_reg    <= '0;
                            status_reg <= 1'b1;
                            sum_reg    <= 8'h00;
                            state_reg  <= ST_ADDR;
                        end else begin
                            idx_reg   <= IW'(scan_pos - SW'(1));
                            state_reg <= ST_RD_MEM;
                        end
                    end
                end
                ST_RD_MEM: begin
                    state_reg <= ST_RD_LOAD;
                end
                ST_RD_LOAD: begin
                    state_reg <= ST_RD_SUM;
                end
                ST_RD_SUM: begin
                    if (!cks_busy) begin
                        rdata_reg <= cks_value;
                        sum_reg   <= cks_sum;
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    addr_reg  <= status_reg ? '0
                               : base_reg + ADDR_W'(n_eff) + ADDR_W'(prod_idx);
                    end_reg   <= base_reg + ADDR_W'(n_eff) + ADDR_W'(prod_end);
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // Hold until the output register is free, then load it.
                    if (out_free) begin
                        out_rdata_reg   <= rdata_reg;
                        out_idx_reg     <= idx_reg;
                        out_addr_reg    <= addr_reg;
                        out_sum_reg     <= sum_reg;
                        out_cleared_reg <= cleared_reg;
                        out_status_reg  <= status_reg;
                        out_end_reg     <= end_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- result channel ----------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_end_reg, out_cleared_reg, out_sum_reg,
                       out_addr_reg, 4'(out_idx_reg), out_rdata_reg};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the wear-leveled ring store.
// Drives requests and register writes, predicts every result in place and checks it.
// Depends on wlrs_pkg and wear_leveling_ring_store_top.
module tb_top;
    import wlrs_pkg::*;

    localparam int SLOT_LIMIT      = 16;      // ring depth of the block
    localparam int BYTE_LIMIT      = 8;       // largest packet size
    localparam int HOLD_CYCLES     = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES   = 64;      // quiet time at the end of the run
    localparam int WATCHDOG_CYCLES = 600000;  // generous upper bound on the run
    localparam int RANDOM_PHASES   = 14;
    localparam int PHASE_ITEMS     = 125;

    // Index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    typedef struct packed {
        logic              req;
        logic [DATA_W-1:0] data;
    } store_req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [3:0]  slot_index;
        logic [15:0] slot_address;
        logic [7:0]  checksum;
        logic        ring_cleared;
        logic        status_code;
        logic [15:0] end_address;
    } store_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the store: registers, slot marks and packets.
    logic [15:0] reg_base  = 16'd0;
    logic [4:0]  reg_slots = 5'd4;
    logic [3:0]  reg_bytes = 4'd2;
    logic [4:0]  slot_mark [SLOT_LIMIT];
    logic [63:0] slot_pkt  [SLOT_LIMIT];

    store_req_t    pending_requests[$];  // requests not yet offered
    store_result_t results_due[$];       // predicted results, oldest first

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_done     = 0;
    int unsigned hold_left      = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    wear_leveling_ring_store_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [63:0] packet_data
        .s_tuser   (s_tuser),    // [0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [63:0] read_data .. [108:93] end_address
        .m_tuser   (m_tuser),    // [0] status_code
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Work out the result of one request and advance the shadow store.
    function automatic store_result_t store_request(input logic req,
                                                    input logic [63:0] data);
        store_result_t r;
        int            n;
        int            b;
        int            pos;
        int            i;
        logic [63:0]   keep;
        logic [63:0]   src;
        logic [7:0]    sum;
        r = '0;
        src = '0;
        // Clamp the slot count and packet size into their legal ranges.
        n = (reg_slots == 0) ? 1 : (reg_slots > SLOT_LIMIT) ? SLOT_LIMIT : int'(reg_slots);
        b = (reg_bytes == 0) ? 1 : (reg_bytes > BYTE_LIMIT) ? BYTE_LIMIT : int'(reg_bytes);
        keep = (b >= 8) ? '1 : ((64'd1 << (8 * b)) - 64'd1);
        // First empty mark inside the active ring; stale marks above n are ignored.
        pos = n;
        for (i = n - 1; i >= 0; i--)
            if (slot_mark[i] == '0) pos = i;
        if (req == REQ_SAVE) begin
            src = data & keep;
            if (pos >= n) begin
                // Full ring: drop every mark and restart at slot 0.
                for (i = 0; i < SLOT_LIMIT; i++) slot_mark[i] = '0;
                r.ring_cleared = 1'b1;
                pos = 0;
            end
            slot_pkt[pos]  = src;
            slot_mark[pos] = 5'(pos + 1);
            r.slot_index   = 4'(pos);
            r.slot_address = 16'(reg_base + n + pos * b);
        end else if (pos == 0) begin
            // Nothing saved yet: flag it and leave the data fields at zero.
            r.status_code = 1'b1;
        end else begin
            // Mask to the current size, which may differ from the size at save time.
            src            = slot_pkt[pos - 1] & keep;
            r.read_data    = src;
            r.slot_index   = 4'(pos - 1);
            r.slot_address = 16'(reg_base + n + (pos - 1) * b);
        end
        sum = '0;
        for (i = 0; i < 8; i++) sum += src[8 * i +: 8];
        r.checksum    = sum;
        r.end_address = 16'(reg_base + n * (1 + b));
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, field, got, want);
        mismatches++;
    endtask

    // Request driver: predict on every transfer, then offer the next queued item
    // unless this cycle is picked as a sender gap.
    always @(posedge aclk) begin : drive_requests
        store_req_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) results_due.push_back(store_request(s_tuser, s_tdata));
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                item = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= item.req;
                s_tdata  <= item.data;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off of the receiver, counted here so the stall pattern stays independent.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Result monitor: check each transfer against the oldest prediction, then
    // pick the ready level for the next cycle.
    always @(posedge aclk) begin : check_results
        store_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_tdata[63:0] !== want.read_data)
                        report_mismatch("read_data", m_tdata[63:0], want.read_data);
                    if (m_tdata[67:64] !== want.slot_index)
                        report_mismatch("slot_index", m_tdata[67:64], want.slot_index);
                    if (m_tdata[83:68] !== want.slot_address)
                        report_mismatch("slot_address", m_tdata[83:68], want.slot_address);
                    if (m_tdata[91:84] !== want.checksum)
                        report_mismatch("checksum", m_tdata[91:84], want.checksum);
                    if (m_tdata[92] !== want.ring_cleared)
                        report_mismatch("ring_cleared", m_tdata[92], want.ring_cleared);
                    if (m_tdata[108:93] !== want.end_address)
                        report_mismatch("end_address", m_tdata[108:93], want.end_address);
                    if (m_tdata[OUT_W-1:109] !== '0)
                        report_mismatch("tdata padding", m_tdata[OUT_W-1:109], '0);
                    if (m_tuser !== want.status_code)
                        report_mismatch("status_code", m_tuser, want.status_code);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run with a failure once the cycle count reaches its upper bound.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == WATCHDOG_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Write one register and mirror it into the shadow copy on the transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BASE:  reg_base  = val;
            CFG_SLOTS: reg_slots = val[4:0];
            CFG_BYTES: reg_bytes = val[3:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every queued request is sent and every result is back.
    task automatic wait_idle;
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || results_due.size() != 0);
    endtask

    task automatic queue_request(input logic req, input logic [63:0] data);
        pending_requests.push_back('{req: req, data: data});
    endtask

    task automatic queue_random_request;
        logic [63:0] data;
        int          pick;
        pick = $urandom_range(7);
        data = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        queue_request(($urandom_range(99) < 55) ? REQ_SAVE : REQ_READ, data);
    endtask

    // New register setting for a phase: extremes mixed in, small rings favored,
    // unused upper data bits randomized.
    task automatic random_config;
        logic [15:0] base;
        logic [4:0]  slots;
        int          pick;
        pick = $urandom_range(3);
        base = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        pick = $urandom_range(7);
        case (pick)
            0:       slots = 5'd0;
            1:       slots = 5'($urandom_range(31, 17));
            2:       slots = 5'd16;
            default: slots = 5'($urandom_range(6, 1));
        endcase
        write_reg(CFG_BASE, base);
        write_reg(CFG_SLOTS, (16'($urandom) & 16'hFFE0) | 16'(slots));
        write_reg(CFG_BYTES, 16'($urandom));
        if ($urandom_range(3) == 0) write_reg(CFG_NONE, 16'($urandom));
    endtask

    initial begin : stimulus
        int ph;
        int k;
        for (k = 0; k < SLOT_LIMIT; k++) slot_mark[k] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset setting: read of an empty store, byte masking,
        // filling the ring and the save that clears it.
        queue_request(REQ_READ, '1);
        queue_request(REQ_SAVE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(REQ_READ, '0);
        queue_request(REQ_SAVE, 64'h0);
        queue_request(REQ_SAVE, 64'h0123_4567_89AB_CDEF);
        queue_request(REQ_SAVE, 64'hFF00_FF00_FF00_FF00);
        queue_request(REQ_SAVE, 64'h8000_0000_0000_0001);
        queue_request(REQ_READ, '0);
        wait_idle();

        // Zero slot count and zero packet size act as one; address wraps at the top.
        write_reg(CFG_SLOTS, 16'd0);
        write_reg(CFG_BYTES, 16'd0);
        write_reg(CFG_BASE, 16'hFFFF);
        queue_request(REQ_SAVE, '1);
        queue_request(REQ_SAVE, 64'h0000_0000_0000_00A5);
        queue_request(REQ_READ, '0);
        wait_idle();

        // Oversized count and size clamp to the largest ring and packet.
        write_reg(CFG_SLOTS, 16'd31);
        write_reg(CFG_BYTES, 16'd15);
        write_reg(CFG_BASE, 16'hFFF0);
        for (k = 0; k < 10; k++) queue_request(REQ_SAVE, {$urandom, $urandom});
        wait_idle();

        // Shrink the packet after saving: the read comes back masked.
        write_reg(CFG_BYTES, 16'd1);
        queue_request(REQ_READ, '0);
        wait_idle();

        // Shrink the ring below the used marks: the marks above it are stale.
        write_reg(CFG_SLOTS, 16'd3);
        write_reg(CFG_BYTES, 16'd9);
        queue_request(REQ_READ, '0);
        queue_request(REQ_SAVE, {$urandom, $urandom});
        queue_request(REQ_READ, '0);
        wait_idle();

        // Random part: rotate through the idling patterns, new registers per phase.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            random_config();
            if (ph % 4 == 0) begin
                // Stall the receiver long enough for the block to back up its input.
                @(posedge aclk);
                holds_asked <= holds_asked + 1;
            end
            repeat (PHASE_ITEMS / 2) queue_random_request();
            // Pause mid-phase until all results are in, then continue.
            wait_idle();
            repeat (PHASE_ITEMS - PHASE_ITEMS / 2) queue_random_request();
            wait_idle();
        end

        // Drain, let any stray result show up, then give the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (results_due.size() != 0)
            report_mismatch("results still missing", 64'(results_due.size()), '0);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
